FILE: hw/rtl/lgpl_pkg.sv
// Shared types and constants for the log-gamma piecewise-linear table unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lgpl_pkg;
  localparam int XW = 48;
  localparam int IW = 52;
  localparam int SW = 32;
  localparam int NW = 12;
  localparam int PW = XW + SW + 1;           // signed product width
  localparam logic [NW-1:0] RESET_ENTRIES = 12'd2000;

  typedef enum logic {REQ_EVAL = 1'b0, REQ_LOAD = 1'b1} req_t;
  typedef enum logic [1:0] {ST_OK = 2'd0, ST_BELOW = 2'd1, ST_SAT = 2'd2} status_t;
endpackage
`default_nettype wire

FILE: hw/rtl/lgpl_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on lgpl_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface lgpl_req_if;
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic [lgpl_pkg::XW-1:0] x_value;
  logic [10:0]             entry_index;
  logic [lgpl_pkg::XW-1:0] entry_boundary;
  logic signed [lgpl_pkg::IW-1:0] entry_intercept;
  logic signed [lgpl_pkg::SW-1:0] entry_slope;
  logic                    last_in;
  modport source (output valid, req_type, x_value, entry_index, entry_boundary,
                  entry_intercept, entry_slope, last_in, input ready);
  modport sink (input valid, req_type, x_value, entry_index, entry_boundary,
                entry_intercept, entry_slope, last_in, output ready);
endinterface

interface lgpl_res_if;
  logic                           valid;
  logic                           ready;
  logic signed [lgpl_pkg::IW-1:0] result_value;
  logic [1:0]                     status;
  logic                           last_out;
  modport source (output valid, result_value, status, last_out, input ready);
  modport sink (input valid, result_value, status, last_out, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/lgpl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lgpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/lgpl_search_level.sv
// One level of the pipelined binary search: a boundary RAM holding the
// entries this level can probe, plus the lo/hi narrowing. Depends on lgpl_pkg, lgpl_ram.
`timescale 1ns / 1ps
`default_nettype none
module lgpl_search_level #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic                    we,
  input  wire logic [AW-1:0]           waddr,
  input  wire logic [lgpl_pkg::XW-1:0] wdata,
  // probe read from the boundary RAM; the decision uses its registered read data
  input  wire logic [AW:0]             lo_in,
  input  wire logic [AW:0]             hi_in,
  input  wire logic [lgpl_pkg::XW-1:0] x_in,
  output logic      [AW:0]             lo_out,
  output logic      [AW:0]             hi_out
);
  logic [AW:0] mid, lo_q, hi_q, mid_q;
  logic [lgpl_pkg::XW-1:0] bnd, x_q;
  logic active_q;

  assign mid = lo_in + ((hi_in - lo_in) >> 1);

  lgpl_ram #(.WIDTH(lgpl_pkg::XW), .DEPTH(DEPTH)) u_bnd (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(en), .raddr(mid[AW-1:0]), .rdata(bnd)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      lo_q     <= lo_in;
      hi_q     <= hi_in;
      mid_q    <= mid;
      x_q      <= x_in;
      active_q <= (hi_in - lo_in) > 1;
    end
  end

  always_comb begin
    lo_out = lo_q;
    hi_out = hi_q;
    if (active_q) begin
      if (bnd <= x_q) lo_out = mid_q;
      else            hi_out = mid_q;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/lgpl_mac.sv
// Slope multiply, rounding and saturating add over three register stages.
// Depends on lgpl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lgpl_mac (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [lgpl_pkg::XW-1:0]        x_in,
  input  wire logic signed [lgpl_pkg::SW-1:0] slope,
  input  wire logic signed [lgpl_pkg::IW-1:0] icpt,
  output logic signed [lgpl_pkg::IW-1:0]      sum_out,
  output logic                                sat_out
);
  localparam int XH = lgpl_pkg::XW - 24;
  // |q| reaches 2^53 and the intercept 2^51, so the sum needs IW+3 bits
  localparam logic signed [lgpl_pkg::IW+2:0] SAT_HI = {4'b0000, {(lgpl_pkg::IW-1){1'b1}}};
  localparam logic signed [lgpl_pkg::IW+2:0] SAT_LO = {4'b1111, {(lgpl_pkg::IW-1){1'b0}}};
  // x split in two 24-bit halves so each multiplier stays near 32x32
  logic signed [24+lgpl_pkg::SW:0]  p_lo;
  logic signed [XH+lgpl_pkg::SW:0]  p_hi;
  logic signed [lgpl_pkg::IW-1:0]   icpt_a, icpt_b;
  logic signed [lgpl_pkg::PW:0]     prod;
  logic signed [lgpl_pkg::PW:0]     q;
  logic signed [lgpl_pkg::IW+2:0]   sum_w;
  logic                             sat_hi, sat_lo;

  always_ff @(posedge clk) begin
    if (en) begin
      p_lo   <= $signed({1'b0, x_in[23:0]}) * slope;
      p_hi   <= $signed({1'b0, x_in[lgpl_pkg::XW-1:24]}) * slope;
      icpt_a <= icpt;
      prod   <= (lgpl_pkg::PW+1)'(p_hi) * (lgpl_pkg::PW+1)'(2**24)
                + (lgpl_pkg::PW+1)'(p_lo);
      icpt_b <= icpt_a;
      sum_out <= sat_hi ? SAT_HI[lgpl_pkg::IW-1:0] :
                 sat_lo ? SAT_LO[lgpl_pkg::IW-1:0] : sum_w[lgpl_pkg::IW-1:0];
      sat_out <= sat_hi || sat_lo;
    end
  end

  // round to nearest, ties toward +inf: floor((p + 2^25) / 2^26)
  assign q      = (prod + (lgpl_pkg::PW+1)'(2**25)) >>> 26;
  assign sum_w  = (lgpl_pkg::IW+3)'(icpt_b) + (lgpl_pkg::IW+3)'(q);
  assign sat_hi = sum_w > SAT_HI;
  assign sat_lo = sum_w < SAT_LO;
endmodule
`default_nettype wire

FILE: hw/rtl/log_gamma_piecewise_linear_table_unit.sv
// Top level of the log-gamma piecewise-linear table unit.
// Depends on lgpl_pkg, lgpl_if, lgpl_ram, lgpl_search_level, lgpl_mac.
`timescale 1ns / 1ps
`default_nettype none
// Evaluates log-gamma by linear interpolation over a loaded segment table.
// One evaluate request enters per cycle. An evaluate result passes through one
// search level per two stages (boundary RAM read, compare), then a coefficient
// RAM read and three multiply/round/saturate stages. The whole pipe advances
// together, so a held result stalls input. A load request waits until no
// evaluate is in flight, so a search never sees the table change under it; loads
// write every search level's copy of the boundary table and the coefficient
// tables in the cycle they are accepted.
// Entries must be loaded before they are searched; no clearing pass exists.
module log_gamma_piecewise_linear_table_unit #(
  parameter int TABLE_ENTRIES = 2048
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [lgpl_pkg::NW-1:0] cfg_wdata,
  lgpl_req_if.sink                     req,
  lgpl_res_if.source                   res
);
  localparam int AW   = $clog2(TABLE_ENTRIES);
  localparam int LVL  = AW;
  localparam int MST  = 3;
  localparam int DEP  = 2 * LVL + 1 + MST;

  logic [lgpl_pkg::NW-1:0] entries_in_use;
  logic en;
  logic ld;
  logic busy;
  logic [AW-1:0] widx;

  assign en   = !res.valid || res.ready;
  assign ld   = req.valid && req.ready && req.req_type == lgpl_pkg::REQ_LOAD &&
                32'(req.entry_index) < TABLE_ENTRIES;
  assign widx = AW'(req.entry_index);

  always_ff @(posedge clk) begin
    if (rst) entries_in_use <= lgpl_pkg::RESET_ENTRIES;
    else if (cfg_we) entries_in_use <= cfg_wdata;
  end

  // clamp n to 1..TABLE_ENTRIES
  logic [AW:0] n_clamp;
  always_comb begin
    if (entries_in_use == '0) n_clamp = (AW+1)'(1);
    else if (32'(entries_in_use) > TABLE_ENTRIES) n_clamp = (AW+1)'(TABLE_ENTRIES);
    else n_clamp = (AW+1)'(entries_in_use);
  end

  // side-band per stage: valid, x, last; each search level spans two stages
  logic [DEP:0]            v_p;
  logic [lgpl_pkg::XW-1:0] x_p [DEP+1];
  logic [DEP:0]            l_p;
  always_ff @(posedge clk) begin
    if (rst) v_p[DEP:1] <= '0;
    else if (en) v_p[DEP:1] <= v_p[DEP-1:0];
    if (en) begin
      for (int i = 1; i <= DEP; i++) begin
        x_p[i] <= x_p[i-1];
        l_p[i] <= l_p[i-1];
      end
    end
  end
  assign v_p[0] = req.valid && req.req_type == lgpl_pkg::REQ_EVAL;
  assign x_p[0] = req.x_value;
  assign l_p[0] = req.last_in;

  assign busy      = |v_p[DEP:1];
  assign req.ready = en && !(req.req_type == lgpl_pkg::REQ_LOAD && busy);

  logic [AW:0] lo_s [LVL+1];
  logic [AW:0] hi_s [LVL+1];
  logic [AW:0] lo_r [LVL];
  logic [AW:0] hi_r [LVL];
  assign lo_s[0] = '0;
  assign hi_s[0] = n_clamp;

  for (genvar g = 0; g < LVL; g++) begin : g_lvl
    lgpl_search_level #(.DEPTH(TABLE_ENTRIES), .AW(AW)) u_lvl (
      .clk(clk), .en(en), .we(ld), .waddr(widx), .wdata(req.entry_boundary),
      .lo_in(lo_s[g]), .hi_in(hi_s[g]), .x_in(x_p[2*g]),
      .lo_out(lo_r[g]), .hi_out(hi_r[g])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        lo_s[g+1] <= lo_r[g];
        hi_s[g+1] <= hi_r[g];
      end
    end
  end

  // below-first-boundary check: entry 0 copy kept in a register
  logic [lgpl_pkg::XW-1:0] b0;
  logic below;
  always_ff @(posedge clk) begin
    if (ld && widx == '0) b0 <= req.entry_boundary;
  end
  // compare made at entry, carried with the item on a one-bit line
  logic [DEP:0] bl_p;
  assign bl_p[0] = req.x_value < b0;
  always_ff @(posedge clk) begin
    if (en) bl_p[DEP:1] <= bl_p[DEP-1:0];
  end
  assign below = bl_p[DEP];

  // coefficient read at stage 2*LVL
  logic signed [lgpl_pkg::IW-1:0] icpt;
  logic signed [lgpl_pkg::SW-1:0] slope;
  lgpl_ram #(.WIDTH(lgpl_pkg::IW), .DEPTH(TABLE_ENTRIES)) u_icpt (
    .clk(clk), .we(ld), .waddr(widx), .wdata(req.entry_intercept),
    .re(en), .raddr(lo_s[LVL][AW-1:0]), .rdata(icpt)
  );
  lgpl_ram #(.WIDTH(lgpl_pkg::SW), .DEPTH(TABLE_ENTRIES)) u_slope (
    .clk(clk), .we(ld), .waddr(widx), .wdata(req.entry_slope),
    .re(en), .raddr(lo_s[LVL][AW-1:0]), .rdata(slope)
  );

  logic signed [lgpl_pkg::IW-1:0] sum;
  logic sat;
  lgpl_mac u_mac (
    .clk(clk), .en(en), .x_in(x_p[2*LVL+1]), .slope(slope), .icpt(icpt),
    .sum_out(sum), .sat_out(sat)
  );

  assign res.valid        = v_p[DEP];
  assign res.last_out     = l_p[DEP];
  assign res.result_value = below ? '0 : sum;
  assign res.status       = below ? lgpl_pkg::ST_BELOW :
                            sat ? lgpl_pkg::ST_SAT : lgpl_pkg::ST_OK;
endmodule
`default_nettype wire

FILE: dv/lgpl_checker.sv
// Checker for the log-gamma table unit: watches the config port and both channels,
// predicts every evaluate result and compares it with what the unit returns.
// Depends on lgpl_pkg and lgpl_if.
`timescale 1ns / 1ps
module lgpl_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [11:0]     cfg_wdata,
  lgpl_req_if             req,
  lgpl_res_if             res,
  output int              fail_count,
  output int              pending
);
  typedef struct packed {
    logic signed [lgpl_pkg::IW-1:0] value;
    lgpl_pkg::status_t              status;
    logic                           last;
  } lg_result_t;

  localparam int DEPTH = 2048;

  logic [lgpl_pkg::XW-1:0]        boundary_mem [DEPTH];
  logic signed [lgpl_pkg::IW-1:0] intercept_mem [DEPTH];
  logic signed [lgpl_pkg::SW-1:0] slope_mem [DEPTH];
  logic [lgpl_pkg::NW-1:0]        segs_in_use;
  lg_result_t                     lgamma_q [$];

  function automatic lg_result_t lgamma_eval(logic [lgpl_pkg::XW-1:0] x, logic last);
    int n, lo, hi, mid;
    logic signed [127:0] xs, ms, prod, sum;
    lg_result_t r;
    r.last = last;
    if (x < boundary_mem[0]) begin
      r.value = '0;
      r.status = lgpl_pkg::ST_BELOW;
      return r;
    end
    n = segs_in_use;
    if (n < 1) n = 1;
    if (n > DEPTH) n = DEPTH;
    lo = 0;
    hi = n;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (boundary_mem[mid] <= x) lo = mid;
      else hi = mid;
    end
    xs = {80'd0, x};
    ms = {{96{slope_mem[lo][lgpl_pkg::SW-1]}}, slope_mem[lo]};
    prod = xs * ms;
    // round half toward +inf, Q.42 -> Q.16
    sum = ((prod + (128'sd1 <<< 25)) >>> 26) +
          $signed({{76{intercept_mem[lo][lgpl_pkg::IW-1]}}, intercept_mem[lo]});
    r.status = lgpl_pkg::ST_OK;
    if (sum > 128'sd2251799813685247) begin
      sum = 128'sd2251799813685247;
      r.status = lgpl_pkg::ST_SAT;
    end else if (sum < -128'sd2251799813685248) begin
      sum = -128'sd2251799813685248;
      r.status = lgpl_pkg::ST_SAT;
    end
    r.value = sum[lgpl_pkg::IW-1:0];
    return r;
  endfunction

  assign pending = lgamma_q.size();

  always @(posedge clk) begin
    lg_result_t e;
    if (rst) begin
      segs_in_use <= lgpl_pkg::RESET_ENTRIES;
      lgamma_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) segs_in_use <= cfg_wdata;
      if (req.valid && req.ready) begin
        if (req.req_type == lgpl_pkg::REQ_LOAD) begin
          boundary_mem[req.entry_index] = req.entry_boundary;
          intercept_mem[req.entry_index] = req.entry_intercept;
          slope_mem[req.entry_index] = req.entry_slope;
        end else begin
          lgamma_q.push_back(lgamma_eval(req.x_value, req.last_in));
        end
      end
      if (res.valid && res.ready) begin
        if (lgamma_q.size() == 0) begin
          $display("%0t: unexpected result value=%0d status=%0d last=%0b", $time,
                   res.result_value, res.status, res.last_out);
          fail_count <= fail_count + 1;
        end else begin
          e = lgamma_q.pop_front();
          if (e.value !== res.result_value || e.status !== res.status ||
              e.last !== res.last_out) begin
            $display("%0t: mismatch exp value=%0d status=%0d last=%0b", $time,
                     e.value, e.status, e.last);
            $display("%0t:          act value=%0d status=%0d last=%0b", $time,
                     res.result_value, res.status, res.last_out);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: dv/tb_top.sv
// Testbench top for the log-gamma table unit: clock, reset, request stimulus,
// result backpressure and verdict. Depends on lgpl_pkg, lgpl_if, lgpl_checker.
`timescale 1ns / 1ps
module tb_top;
  localparam int DEPTH = 2048;
  // entries 0..DENSE-1 hold real segments; the search path above them is fenced
  localparam int DENSE = 64;
  localparam logic [lgpl_pkg::XW-1:0] X_TOP = '1;

  logic                    clk = 0;
  logic                    rst = 1;
  logic                    cfg_we = 0;
  logic [lgpl_pkg::NW-1:0] cfg_wdata = '0;
  logic [lgpl_pkg::NW-1:0] seg_cur = lgpl_pkg::RESET_ENTRIES;
  logic                    no_idle = 0;
  int                      fail_count, pending;
  logic [lgpl_pkg::XW-1:0] bnd_shadow [DEPTH];
  bit                      written [DEPTH];

  lgpl_req_if req_ch ();
  lgpl_res_if res_ch ();

  log_gamma_piecewise_linear_table_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(req_ch.sink), .res(res_ch.source)
  );

  lgpl_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(req_ch), .res(res_ch), .fail_count(fail_count), .pending(pending)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  initial begin
    req_ch.valid = 0;
    req_ch.req_type = lgpl_pkg::REQ_EVAL;
    req_ch.x_value = '0;
    req_ch.entry_index = '0;
    req_ch.entry_boundary = '0;
    req_ch.entry_intercept = '0;
    req_ch.entry_slope = '0;
    req_ch.last_in = 0;
    res_ch.ready = 0;
  end

  // result side backpressure
  initial begin
    int n;
    @(posedge clk);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 7);
      repeat (n) begin
        res_ch.ready <= 0;
        @(posedge clk);
      end
      res_ch.ready <= 1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
    end
  end

  task automatic send(lgpl_pkg::req_t kind, logic [lgpl_pkg::XW-1:0] x, logic [10:0] idx,
                      logic [lgpl_pkg::XW-1:0] b, logic signed [lgpl_pkg::IW-1:0] icpt,
                      logic signed [lgpl_pkg::SW-1:0] slope, logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      req_ch.valid <= 0;
      @(posedge clk);
    end
    req_ch.valid <= 1;
    req_ch.req_type <= kind;
    req_ch.x_value <= x;
    req_ch.entry_index <= idx;
    req_ch.entry_boundary <= b;
    req_ch.entry_intercept <= icpt;
    req_ch.entry_slope <= slope;
    req_ch.last_in <= last;
    if (kind == lgpl_pkg::REQ_LOAD) begin
      bnd_shadow[idx] = b;
      written[idx] = 1'b1;
    end
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic eval_x(logic [lgpl_pkg::XW-1:0] x);
    send(lgpl_pkg::REQ_EVAL, x, 11'($urandom), lgpl_pkg::XW'({$urandom, $urandom}),
         lgpl_pkg::IW'({$urandom, $urandom}), $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic load(logic [10:0] idx, logic [lgpl_pkg::XW-1:0] b,
                      logic signed [lgpl_pkg::IW-1:0] icpt,
                      logic signed [lgpl_pkg::SW-1:0] slope);
    send(lgpl_pkg::REQ_LOAD, lgpl_pkg::XW'({$urandom, $urandom}), idx, b, icpt, slope,
         1'($urandom_range(0, 1)));
  endtask

  task automatic load_small(logic [10:0] idx, logic [lgpl_pkg::XW-1:0] b);
    logic signed [lgpl_pkg::IW-1:0] icpt;
    logic signed [lgpl_pkg::SW-1:0] slope;
    icpt = lgpl_pkg::IW'($signed($urandom_range(0, 32'hFFFFF)) - 524288);
    slope = $signed($urandom_range(0, 32'h3FFFFFF)) - 33554432;
    load(idx, b, icpt, slope);
  endtask

  // Walk the search for the largest x below all-ones and give every unloaded
  // probe an all-ones bound. Loaded low entries stay below all-ones, so any
  // x below all-ones turns left only onto loaded entries.
  task automatic guard_path();
    int n, lo, hi, mid;
    n = seg_cur;
    if (n < 1) n = 1;
    if (n > DEPTH) n = DEPTH;
    lo = 0;
    hi = n;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (!written[mid]) load_small(11'(mid), X_TOP);
      if (bnd_shadow[mid] <= X_TOP - 1) lo = mid;
      else hi = mid;
    end
  endtask

  // drain the pipe, then let a few more cycles go by
  task automatic drain();
    req_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_segments(logic [lgpl_pkg::NW-1:0] v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    seg_cur = v;
    guard_path();
  endtask

  task automatic random_request();
    int idx, k;
    logic [lgpl_pkg::XW-1:0] x, b;
    logic signed [lgpl_pkg::IW-1:0] icpt;
    logic signed [lgpl_pkg::SW-1:0] slope;
    idx = $urandom_range(0, DENSE - 1);
    k = $urandom_range(0, 9);
    if (k < 2) begin
      b = ($urandom_range(0, 1) == 1) ? bnd_shadow[idx] : lgpl_pkg::XW'({$urandom, $urandom});
      if (b == X_TOP) b = X_TOP - 1;
      if ($urandom_range(0, 1) == 1) begin
        icpt = lgpl_pkg::IW'({$urandom, $urandom});
        slope = $urandom;
        load(11'(idx), b, icpt, slope);
      end else begin
        load_small(11'(idx), b);
      end
    end else begin
      if (k < 7) x = bnd_shadow[idx] + lgpl_pkg::XW'($signed($urandom_range(0, 8)) - 4);
      else if (k < 9) x = lgpl_pkg::XW'({$urandom, $urandom});
      else x = ($urandom_range(0, 1) == 1) ? '0 : X_TOP - 1;
      if (x == X_TOP) x = X_TOP - 1;
      eval_x(x);
    end
  endtask

  initial begin
    logic [lgpl_pkg::XW-1:0] b;
    logic [lgpl_pkg::NW-1:0] seg_set [10] = '{12'd1, 12'd0, 12'd4095, 12'd2048, 12'd2047,
                                              12'd3, 12'hAAA, 12'h555, 12'd1024, 12'd2000};
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // low entries with ascending bounds, then fence the path above them
    no_idle = 1;
    b = 48'd100;
    for (int i = 0; i < DENSE; i++) begin
      load_small(11'(i), b);
      b = b + lgpl_pkg::XW'($urandom_range(1, 1 << 20));
    end
    guard_path();
    no_idle = 0;

    // directed, reset segment count
    eval_x('0);
    eval_x(48'd99);
    eval_x(bnd_shadow[0]);
    eval_x(bnd_shadow[DENSE-1]);
    eval_x(bnd_shadow[DENSE-1] + 48'd1);
    eval_x(X_TOP - 1);

    // directed, single segment: saturation and rounding ties
    set_segments(12'd1);
    load(11'd0, 48'd5, 52'sh7FFFFFFFFFFFF, 32'sh7FFFFFFF);
    eval_x(X_TOP);
    eval_x(48'd4);
    load(11'd0, 48'd0, -52'sh8000000000000, -32'sh80000000);
    eval_x(X_TOP);
    eval_x('0);
    load(11'd0, 48'd0, 52'sd0, 32'sd1);
    eval_x(48'd1 << 25);
    eval_x((48'd3 << 25));
    load(11'd0, 48'd0, 52'sd0, -32'sd1);
    eval_x(48'd1 << 25);
    eval_x((48'd3 << 25));
    load(11'd0, 48'd100, 52'sd7, 32'sd3);
    eval_x(48'd100);

    // random phases across segment counts
    for (int p = 0; p < 10; p++) begin
      set_segments(seg_set[p]);
      no_idle = (p == 4);
      for (int i = 0; i < 90; i++) random_request();
    end
    no_idle = 0;

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("log_gamma_piecewise_linear_table_unit test passed");
    end else begin
      $display("log_gamma_piecewise_linear_table_unit test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("log_gamma_piecewise_linear_table_unit test failed");
    $finish;
  end
endmodule
